// File: design/flm_pkg.sv
`timescale 1ns / 1ps
package flm_pkg;

   localparam int FIELD_W = 10;

   typedef enum logic {
      OP_DRAW  = 1'b0,
      OP_CLEAR = 1'b1
   } op_type;

endpackage

// File: design/flm_div.sv
`timescale 1ns / 1ps
module flm_div #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      start,
   input  logic [flm_pkg::FIELD_W+FRAC_BITS-1:0]     dividend,
   input  logic [flm_pkg::FIELD_W-1:0]               divisor,
   output logic                                      done,
   output logic [flm_pkg::FIELD_W+FRAC_BITS-1:0]     quotient
);

   localparam int NUM_W = flm_pkg::FIELD_W + FRAC_BITS;
   localparam int CNT_W = $clog2(NUM_W + 1);
   localparam int FW    = flm_pkg::FIELD_W;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [FW-1:0]    rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [FW-1:0]    div_ff, div_in;

   logic [FW:0]      rem_sh;
   logic [FW+1:0]    diff;
   logic             take;

   // restoring division, one quotient bit per cycle; dividend shifts out as quotient shifts in
   always_comb begin
      rem_sh = {rem_ff, quo_ff[NUM_W-1]};
      diff   = {1'b0, rem_sh} - {2'b00, div_ff};
      take   = !diff[FW+1];

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in = take ? diff[FW-1:0] : rem_sh[FW-1:0];
         quo_in = {quo_ff[NUM_W-2:0], take};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: design/floating_horizon_line_mask.sv
// Draw item: ST_RD_S and ST_RD_E read the store, then ST_EMIT loads the result register once it
//   is free; a vertical item then ends, else the divider runs, then the walk does one column/cycle.
// Clear item: ST_EMIT loads the result register once it is free; a sweep of all columns then holds off input.
// One item at a time; the horizon RAM (1 read + 1 write port) paces the column walk.
// Reset (synchronous, active high) starts a zeroing sweep of all NUM_COLUMNS columns of the RAM.
`timescale 1ns / 1ps
module floating_horizon_line_mask #(
   parameter int NUM_COLUMNS = 1024,
   parameter int FRAC_BITS   = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_operation,
   input  logic [flm_pkg::FIELD_W-1:0] req_x_start,
   input  logic [flm_pkg::FIELD_W-1:0] req_y_start,
   input  logic [flm_pkg::FIELD_W-1:0] req_x_end,
   input  logic [flm_pkg::FIELD_W-1:0] req_y_end,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_vector_valid,
   output logic [flm_pkg::FIELD_W-1:0] rsp_out_x_start,
   output logic [flm_pkg::FIELD_W-1:0] rsp_out_y_start,
   output logic [flm_pkg::FIELD_W-1:0] rsp_out_x_end,
   output logic [flm_pkg::FIELD_W-1:0] rsp_out_y_end
);

   localparam int FW     = flm_pkg::FIELD_W;
   localparam int ADDR_W = $clog2(NUM_COLUMNS);
   localparam int XE_W   = FW + 3;
   localparam int NUM_W  = FW + FRAC_BITS;
   localparam int ACC_W  = NUM_W + 1;

   typedef enum logic [7:0] {
      ST_CLEAR = 8'b0000_0001,
      ST_IDLE  = 8'b0000_0010,
      ST_RD_S  = 8'b0000_0100,
      ST_RD_E  = 8'b0000_1000,
      ST_EMIT  = 8'b0001_0000,
      ST_DIV   = 8'b0010_0000,
      ST_WALK  = 8'b0100_0000,
      ST_DRAIN = 8'b1000_0000
   } state_type;

   function automatic logic col_in_range(input logic [FW-1:0] x);
      return XE_W'(x) < XE_W'(NUM_COLUMNS);
   endfunction

   function automatic logic [ADDR_W-1:0] col_addr(input logic [FW-1:0] x);
      logic [XE_W-1:0] e;
      e = XE_W'(x);
      return e[ADDR_W-1:0];
   endfunction

   state_type state_ff, state_in;

   flm_pkg::op_type op_ff, op_in;
   logic [FW-1:0] xs_ff, xs_in, ys_ff, ys_in, xe_ff, xe_in, ye_ff, ye_in;
   logic [FW-1:0] hs_ff, hs_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [FW-1:0] col_ff, col_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in, slope_ff, slope_in;

   logic              p_valid_ff, p_valid_in;
   logic              p_inr_ff, p_inr_in;
   logic [ADDR_W-1:0] p_addr_ff, p_addr_in;
   logic [FW-1:0]     p_h_ff, p_h_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_vec_ff, rsp_vec_in;
   logic [FW-1:0] rsp_xs_ff, rsp_xs_in, rsp_ys_ff, rsp_ys_in;
   logic [FW-1:0] rsp_xe_ff, rsp_xe_in, rsp_ye_ff, rsp_ye_in;

   logic [FW-1:0]     mem [NUM_COLUMNS];
   logic [FW-1:0]     rdata_ff;
   logic              rd_en, wr_en;
   logic [ADDR_W-1:0] rd_addr, wr_addr;
   logic [FW-1:0]     wr_data;

   logic              req_take, slot_free, rsp_load;
   logic [FW-1:0]     xa, xb, ya, yb, dy, span, hs_eff, he_eff;
   logic              neg;
   logic              div_start, div_done;
   logic [NUM_W-1:0]  quotient;

   // segment ordered by column
   always_comb begin
      if (xe_ff >= xs_ff) begin
         xa = xs_ff; xb = xe_ff; ya = ys_ff; yb = ye_ff;
      end else begin
         xa = xe_ff; xb = xs_ff; ya = ye_ff; yb = ys_ff;
      end
      neg    = yb < ya;
      dy     = neg ? (ya - yb) : (yb - ya);
      span   = xb - xa;
      hs_eff = col_in_range(xs_ff) ? hs_ff : '0;
      he_eff = col_in_range(xe_ff) ? rdata_ff : '0;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_load  = (state_ff == ST_EMIT) && slot_free;
   assign div_start = rsp_load && (op_ff == flm_pkg::OP_DRAW) && (xa != xb);

   flm_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({dy, {FRAC_BITS{1'b0}}}),
      .divisor  (span),
      .done     (div_done),
      .quotient (quotient)
   );

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      xs_in      = xs_ff;
      ys_in      = ys_ff;
      xe_in      = xe_ff;
      ye_in      = ye_ff;
      hs_in      = hs_ff;
      clr_in     = clr_ff;
      col_in     = col_ff;
      acc_in     = acc_ff;
      slope_in   = slope_ff;
      p_valid_in = 1'b0;
      p_inr_in   = 1'b0;
      p_addr_in  = col_addr(col_ff);
      p_h_in     = acc_ff[FRAC_BITS +: FW];
      rd_en      = 1'b0;
      rd_addr    = col_addr(col_ff);
      wr_en      = 1'b0;
      wr_addr    = p_addr_ff;
      wr_data    = p_h_ff;

      // walk pipeline write-back: raise only
      if (p_valid_ff && p_inr_ff && (rdata_ff < p_h_ff)) begin
         wr_en = 1'b1;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(NUM_COLUMNS - 1)) begin
               clr_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               op_in = flm_pkg::op_type'(req_operation);
               xs_in = req_x_start;
               ys_in = req_y_start;
               xe_in = req_x_end;
               ye_in = req_y_end;
               state_in = (flm_pkg::op_type'(req_operation) == flm_pkg::OP_CLEAR) ?
                          ST_EMIT : ST_RD_S;
            end
         end
         ST_RD_S: begin
            rd_en    = col_in_range(xs_ff);
            rd_addr  = col_addr(xs_ff);
            state_in = ST_RD_E;
         end
         ST_RD_E: begin
            hs_in    = rdata_ff;
            rd_en    = col_in_range(xe_ff);
            rd_addr  = col_addr(xe_ff);
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (slot_free) begin
               if (op_ff == flm_pkg::OP_CLEAR) begin
                  state_in = ST_CLEAR;
               end else if (xa == xb) begin
                  // vertical segment: single column raised to the first endpoint's height
                  if (col_in_range(xa) && (hs_eff < ys_ff)) begin
                     wr_en   = 1'b1;
                     wr_addr = col_addr(xa);
                     wr_data = ys_ff;
                  end
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               acc_in   = $signed({1'b0, ya, {FRAC_BITS{1'b0}}});
               slope_in = neg ? -$signed({1'b0, quotient}) : $signed({1'b0, quotient});
               col_in   = xa;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            rd_en      = col_in_range(col_ff);
            p_valid_in = 1'b1;
            p_inr_in   = col_in_range(col_ff);
            acc_in     = acc_ff + slope_ff;
            col_in     = col_ff + FW'(1);
            if (col_ff == xb) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_vec_in   = rsp_vec_ff;
      rsp_xs_in    = rsp_xs_ff;
      rsp_ys_in    = rsp_ys_ff;
      rsp_xe_in    = rsp_xe_ff;
      rsp_ye_in    = rsp_ye_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         if (op_ff == flm_pkg::OP_CLEAR) begin
            rsp_vec_in = 1'b0;
            rsp_xs_in  = '0;
            rsp_ys_in  = '0;
            rsp_xe_in  = '0;
            rsp_ye_in  = '0;
         end else begin
            rsp_vec_in = 1'b1;
            rsp_xs_in  = xs_ff;
            rsp_ys_in  = (ys_ff >= hs_eff) ? ys_ff : hs_eff;
            rsp_xe_in  = xe_ff;
            rsp_ye_in  = (ye_ff >= he_eff) ? ye_ff : he_eff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         p_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         p_valid_ff   <= p_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      xs_ff     <= xs_in;
      ys_ff     <= ys_in;
      xe_ff     <= xe_in;
      ye_ff     <= ye_in;
      hs_ff     <= hs_in;
      col_ff    <= col_in;
      acc_ff    <= acc_in;
      slope_ff  <= slope_in;
      p_inr_ff  <= p_inr_in;
      p_addr_ff <= p_addr_in;
      p_h_ff    <= p_h_in;
      rsp_vec_ff <= rsp_vec_in;
      rsp_xs_ff <= rsp_xs_in;
      rsp_ys_ff <= rsp_ys_in;
      rsp_xe_ff <= rsp_xe_in;
      rsp_ye_ff <= rsp_ye_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_vector_valid = rsp_vec_ff;
   assign rsp_out_x_start  = rsp_xs_ff;
   assign rsp_out_y_start  = rsp_ys_ff;
   assign rsp_out_x_end    = rsp_xe_ff;
   assign rsp_out_y_end    = rsp_ye_ff;

   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (rd_en && wr_en) |-> (rd_addr != wr_addr))
      else $error("horizon read and write hit the same column");

   a_walk_pipe_state: assert property (@(posedge clock) disable iff (reset)
      p_valid_ff |-> (state_ff == ST_WALK || state_ff == ST_DRAIN))
      else $error("walk write-back outside column walk");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("slope ready while not waiting for it");

   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register overwritten before transfer");

endmodule
